>>> src/pair_table_engine_macros.svh
// ----------------------------------------------------------------------------
// Pair table engine assertion macros
// Shared property wrappers for the checker of the pair table engine.
// ----------------------------------------------------------------------------
`ifndef PAIR_TABLE_ENGINE_MACROS_SVH
`define PAIR_TABLE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pair table engine: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pair table engine: next-cycle property failed");

`endif

>>> src/pte_pkg.sv
// ----------------------------------------------------------------------------
// Pair table engine package
// Sizes, codes, item types and controller interface types.
// ----------------------------------------------------------------------------
package pte_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned PTR_W   = IDX_W + 1;
  localparam int unsigned EP_W    = 32;
  localparam int unsigned CNT_W   = 7;

  // A free slot holds all ones in both halves.
  localparam logic [EP_W-1:0] EMPTY = '1;

  // Action codes.
  typedef enum logic [2:0] {
    ACT_ADD          = 3'd0,
    ACT_DEL_PAIR     = 3'd1,
    ACT_COUNT_SRC    = 3'd2,
    ACT_FIND_PAIR    = 3'd3,
    ACT_FIND_DEL_SRC = 3'd4,
    ACT_MOVE_TGT     = 3'd5
  } pte_action_e;

  // Input item.
  typedef struct packed {
    logic [2:0]               action;
    logic                     table_select;
    logic signed [EP_W-1:0]   key_source;
    logic signed [EP_W-1:0]   key_target;
  } pte_in_t;

  // Result item.
  typedef struct packed {
    logic                     status;
    logic [IDX_W-1:0]         slot_index;
    logic [CNT_W-1:0]         match_count;
    logic signed [EP_W-1:0]   found_source;
    logic signed [EP_W-1:0]   found_target;
  } pte_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_EV_I,
    ST_RD_K,
    ST_EV_K,
    ST_RESP
  } pte_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rd_i;
    logic rd_k;
    logic inc_i;
    logic inc_k;
    logic cnt_inc;
    logic wr_i_key;
    logic wr_i_empty;
    logic wr_k_move;
    logic latch_move;
    logic set_ok;
    logic set_slot;
    logic set_halves;
  } pte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] act;
    logic       skip;
    logic       hit;
    logic       b_free;
    logic       i_last;
    logic       k_last;
    logic       k_end;
  } pte_sts_t;

endpackage

>>> src/pte_ctrl.sv
// ----------------------------------------------------------------------------
// Pair table engine controller
// Sequences the per-entry scan of each action and the handshakes.
// ----------------------------------------------------------------------------
module pte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pte_pkg::pte_sts_t sts_i,
  output pte_pkg::pte_cmd_t cmd_o
);

  pte_pkg::pte_state_e state_q, state_d;
  logic early_stop;
  logic move_to_b;
  logic k_done;
  logic is_cnt_or_move;

  // Decisions taken on the entry just read.
  always_comb begin
    early_stop = sts_i.hit &&
                 (sts_i.act == pte_pkg::ACT_ADD || sts_i.act == pte_pkg::ACT_DEL_PAIR ||
                  sts_i.act == pte_pkg::ACT_FIND_PAIR ||
                  sts_i.act == pte_pkg::ACT_FIND_DEL_SRC);
    move_to_b  = sts_i.hit && (sts_i.act == pte_pkg::ACT_MOVE_TGT) && !sts_i.k_end;
    k_done     = sts_i.b_free || sts_i.k_last;
    is_cnt_or_move = (sts_i.act == pte_pkg::ACT_COUNT_SRC) ||
                     (sts_i.act == pte_pkg::ACT_MOVE_TGT);
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pte_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pte_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pte_pkg::ST_RD_I;
      end
      pte_pkg::ST_RD_I: begin
        state_d = sts_i.skip ? pte_pkg::ST_RESP : pte_pkg::ST_EV_I;
      end
      pte_pkg::ST_EV_I: begin
        if (early_stop) state_d = pte_pkg::ST_RESP;
        else if (move_to_b) state_d = pte_pkg::ST_RD_K;
        else if (sts_i.i_last) state_d = pte_pkg::ST_RESP;
        else state_d = pte_pkg::ST_RD_I;
      end
      pte_pkg::ST_RD_K: begin
        state_d = pte_pkg::ST_EV_K;
      end
      pte_pkg::ST_EV_K: begin
        if (!k_done) state_d = pte_pkg::ST_RD_K;
        else if (sts_i.i_last) state_d = pte_pkg::ST_RESP;
        else state_d = pte_pkg::ST_RD_I;
      end
      pte_pkg::ST_RESP: begin
        if (!out_stall_i) state_d = pte_pkg::ST_IDLE;
      end
      default: state_d = pte_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      pte_pkg::ST_IDLE: begin
        cmd_o.start = in_valid_i;
      end
      pte_pkg::ST_RD_I: begin
        cmd_o.rd_i = !sts_i.skip;
      end
      pte_pkg::ST_EV_I: begin
        case (sts_i.act)
          pte_pkg::ACT_ADD: begin
            cmd_o.wr_i_key = sts_i.hit;
            cmd_o.set_ok   = sts_i.hit;
          end
          pte_pkg::ACT_DEL_PAIR, pte_pkg::ACT_FIND_DEL_SRC: begin
            cmd_o.wr_i_empty = sts_i.hit;
            cmd_o.set_ok     = sts_i.hit;
            cmd_o.set_halves = sts_i.hit;
          end
          pte_pkg::ACT_COUNT_SRC: begin
            cmd_o.cnt_inc = sts_i.hit;
          end
          pte_pkg::ACT_FIND_PAIR: begin
            cmd_o.set_ok   = sts_i.hit;
            cmd_o.set_slot = sts_i.hit;
          end
          pte_pkg::ACT_MOVE_TGT: begin
            cmd_o.wr_i_empty = sts_i.hit;
            cmd_o.latch_move = sts_i.hit;
          end
          default: begin
          end
        endcase
        // Step to the next entry, or close a full scan.
        if (!early_stop && !move_to_b) begin
          if (sts_i.i_last) cmd_o.set_ok = cmd_o.set_ok || is_cnt_or_move;
          else cmd_o.inc_i = 1'b1;
        end
      end
      pte_pkg::ST_RD_K: begin
        cmd_o.rd_k = 1'b1;
      end
      pte_pkg::ST_EV_K: begin
        cmd_o.wr_k_move = sts_i.b_free;
        cmd_o.inc_k     = !sts_i.b_free;
        if (k_done) begin
          if (sts_i.i_last) cmd_o.set_ok = 1'b1;
          else cmd_o.inc_i = 1'b1;
        end
      end
      pte_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Handshake outputs.
  assign in_stall_o  = (state_q != pte_pkg::ST_IDLE);
  assign out_valid_o = (state_q == pte_pkg::ST_RESP);

endmodule

>>> src/pte_dp.sv
// ----------------------------------------------------------------------------
// Pair table engine datapath
// Table memories with valid bits, scan pointers, compares and result register.
// ----------------------------------------------------------------------------
module pte_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pte_pkg::pte_in_t  in_item_i,
  input  pte_pkg::pte_cmd_t cmd_i,
  output pte_pkg::pte_sts_t sts_o,
  output pte_pkg::pte_out_t out_item_o
);

  localparam int unsigned ROW_W = 2 * pte_pkg::EP_W;

  pte_pkg::pte_in_t in_q;
  pte_pkg::pte_out_t res_q;
  logic [pte_pkg::PTR_W-1:0] i_q;
  logic [pte_pkg::PTR_W-1:0] k_q;
  logic [ROW_W-1:0] mv_q;

  logic [ROW_W-1:0] mem_a [pte_pkg::ENTRIES];
  logic [ROW_W-1:0] mem_b [pte_pkg::ENTRIES];
  logic [pte_pkg::ENTRIES-1:0] vld_a_q;
  logic [pte_pkg::ENTRIES-1:0] vld_b_q;
  logic [ROW_W-1:0] a_rd_q;
  logic [ROW_W-1:0] b_rd_q;
  logic a_rv_q;
  logic b_rv_q;
  logic rd_tbl_q;

  logic tbl_i;
  logic [pte_pkg::IDX_W-1:0] i_idx;
  logic [pte_pkg::IDX_W-1:0] k_idx;
  logic wr_i;
  logic [ROW_W-1:0] wr_i_data;
  logic we_a;
  logic we_b;
  logic re_a;
  logic re_b;
  logic [pte_pkg::IDX_W-1:0] b_waddr;
  logic [pte_pkg::IDX_W-1:0] b_raddr;
  logic [ROW_W-1:0] b_wdata;
  logic [ROW_W-1:0] rdata;
  logic [pte_pkg::EP_W-1:0] rs;
  logic [pte_pkg::EP_W-1:0] rt;
  logic [pte_pkg::EP_W-1:0] ks;
  logic [pte_pkg::EP_W-1:0] kt;
  logic hit;

  // Address and write selection.
  always_comb begin
    ks        = in_q.key_source;
    kt        = in_q.key_target;
    tbl_i     = (in_q.action == pte_pkg::ACT_MOVE_TGT) ? 1'b0 : in_q.table_select;
    i_idx     = i_q[pte_pkg::IDX_W-1:0];
    k_idx     = k_q[pte_pkg::IDX_W-1:0];
    wr_i      = cmd_i.wr_i_key || cmd_i.wr_i_empty;
    wr_i_data = cmd_i.wr_i_key ? {ks, kt} : {pte_pkg::EMPTY, pte_pkg::EMPTY};
    we_a      = wr_i && !tbl_i;
    we_b      = (wr_i && tbl_i) || cmd_i.wr_k_move;
    re_a      = cmd_i.rd_i && !tbl_i;
    re_b      = (cmd_i.rd_i && tbl_i) || cmd_i.rd_k;
    b_waddr   = cmd_i.wr_k_move ? k_idx : i_idx;
    b_wdata   = cmd_i.wr_k_move ? mv_q : wr_i_data;
    b_raddr   = cmd_i.rd_k ? k_idx : i_idx;
  end

  // Table A memory.
  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[i_idx] <= wr_i_data;
    if (re_a) a_rd_q <= mem_a[i_idx];
  end

  // Table B memory.
  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[b_waddr] <= b_wdata;
    if (re_b) b_rd_q <= mem_b[b_raddr];
  end

  // Valid bits: a row never written reads as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= '0;
      vld_b_q  <= '0;
      a_rv_q   <= 1'b0;
      b_rv_q   <= 1'b0;
      rd_tbl_q <= 1'b0;
    end else begin
      if (we_a) vld_a_q[i_idx] <= 1'b1;
      if (we_b) vld_b_q[b_waddr] <= 1'b1;
      if (re_a) a_rv_q <= vld_a_q[i_idx];
      if (re_b) b_rv_q <= vld_b_q[b_raddr];
      if (re_a || re_b) rd_tbl_q <= re_b;
    end
  end

  // Entry just read, with the empty value for rows never written.
  always_comb begin
    if (rd_tbl_q) rdata = b_rv_q ? b_rd_q : {pte_pkg::EMPTY, pte_pkg::EMPTY};
    else rdata = a_rv_q ? a_rd_q : {pte_pkg::EMPTY, pte_pkg::EMPTY};
    rs = rdata[ROW_W-1:pte_pkg::EP_W];
    rt = rdata[pte_pkg::EP_W-1:0];
  end

  // Match test for the current action.
  always_comb begin
    case (in_q.action)
      pte_pkg::ACT_ADD:          hit = (rs == pte_pkg::EMPTY) && (rt == pte_pkg::EMPTY);
      pte_pkg::ACT_DEL_PAIR:     hit = (rs == ks) && (rt == kt);
      pte_pkg::ACT_COUNT_SRC:    hit = (rs == ks);
      pte_pkg::ACT_FIND_PAIR:    hit = (rs == ks) && (rt == kt);
      pte_pkg::ACT_FIND_DEL_SRC: hit = (rs == ks);
      pte_pkg::ACT_MOVE_TGT:     hit = (rt == kt);
      default:                   hit = 1'b0;
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts_o.act    = in_q.action;
    sts_o.skip   = (in_q.action > 3'(pte_pkg::ACT_MOVE_TGT)) ||
                   ((in_q.action == pte_pkg::ACT_COUNT_SRC) && (ks == pte_pkg::EMPTY));
    sts_o.hit    = hit;
    sts_o.b_free = (rs == pte_pkg::EMPTY) && (rt == pte_pkg::EMPTY);
    sts_o.i_last = (i_q == pte_pkg::PTR_W'(pte_pkg::ENTRIES - 1));
    sts_o.k_last = (k_q == pte_pkg::PTR_W'(pte_pkg::ENTRIES - 1));
    sts_o.k_end  = (k_q == pte_pkg::PTR_W'(pte_pkg::ENTRIES));
  end

  // Scan pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      k_q <= '0;
    end else if (cmd_i.start) begin
      i_q <= '0;
      k_q <= '0;
    end else begin
      if (cmd_i.inc_i) i_q <= i_q + 1'b1;
      if (cmd_i.inc_k) k_q <= k_q + 1'b1;
    end
  end

  // Captured item, moved pair and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      in_q               <= in_item_i;
      res_q.status       <= 1'b1;
      res_q.slot_index   <= '0;
      res_q.match_count  <= '0;
      res_q.found_source <= pte_pkg::EMPTY;
      res_q.found_target <= pte_pkg::EMPTY;
    end else begin
      if (cmd_i.set_ok) res_q.status <= 1'b0;
      if (cmd_i.set_slot) res_q.slot_index <= i_idx;
      if (cmd_i.cnt_inc) res_q.match_count <= res_q.match_count + 1'b1;
      if (cmd_i.set_halves) begin
        res_q.found_source <= rs;
        res_q.found_target <= rt;
      end
    end
    if (cmd_i.latch_move) mv_q <= rdata;
  end

  assign out_item_o = res_q;

endmodule

>>> src/pair_table_engine.sv
// ----------------------------------------------------------------------------
// Pair table engine
// Two tables of source/target endpoint pairs with add, delete, count, find,
// find-delete and move actions.
// ----------------------------------------------------------------------------
// Usage: one input item carries an action, a table select and a key pair; it
// is taken when in_valid_i is high and in_stall_o is low. Every item yields
// exactly one result item on the output channel, held until out_stall_i is
// low. The engine handles one item at a time: in_stall_o stays high from the
// accepting edge until the result has been taken.
// Scan: each table entry is probed by a memory read, then a compare. An
// action stops at the first match where it can: add, delete, find and
// find-delete stop there, count scans every entry, and move scans all of
// table A, as it also probes table B for free slots. Undefined actions and
// a count of the empty key answer without a scan. Each table memory has a
// single read port.
// Reset: the valid bits clear at once, so both tables read as empty right
// after reset with no clearing pass. A stalled result simply holds.
// ----------------------------------------------------------------------------
module pair_table_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pte_pkg::pte_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pte_pkg::pte_out_t out_item_o
);

  pte_pkg::pte_cmd_t cmd;
  pte_pkg::pte_sts_t sts;

  // Scan sequencer.
  pte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tables and result.
  pte_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

>>> src/pte_checker.sv
// ----------------------------------------------------------------------------
// Pair table engine checker
// Port-level properties of the one-item-at-a-time handshake.
// ----------------------------------------------------------------------------
`include "pair_table_engine_macros.svh"

module pte_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pte_pkg::pte_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pte_pkg::pte_out_t out_item_o
);

  // An accepted item keeps the input stalled while it is processed.
  `PTE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // No new item is taken while a result waits.
  `PTE_ASSERT_SAME(a_stall_while_result, out_valid_o, in_stall_o)

  // A stalled result holds its value.
  `PTE_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_item_o))

  // Each item gives one result only.
  `PTE_ASSERT_NEXT(a_single_result, out_valid_o && !out_stall_i, !out_valid_o)

endmodule

bind pair_table_engine pte_checker u_pte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
